// ===== hw/rtl/mts_pkg.sv =====
// Shared types and constants for the max tracking stack.
package mts_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = 11;
   localparam int DATA_W      = 32;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1024);
   localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(STACK_DEPTH);

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_PEEK = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [PADDR_W-1:0] {
      REG_CAPACITY_LIMIT = 3'd0
   } reg_addr_type;

   // One stack entry: the value and the running maximum at or below it.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] maxv;
   } entry_type;

endpackage

// ===== hw/rtl/mts_req_if.sv =====
// Request channel interface: operation and push value.
interface mts_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mts_pkg::REQ_W-1:0]              req_type;
   logic signed [mts_pkg::DATA_W-1:0]      push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ===== hw/rtl/mts_rsp_if.sv =====
// Response channel interface: top value, maximum, count and status.
interface mts_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mts_pkg::DATA_W-1:0]      top_value;
   logic signed [mts_pkg::DATA_W-1:0]      largest_value;
   logic [mts_pkg::CNT_W-1:0]              element_count;
   logic [mts_pkg::STATUS_W-1:0]           status;

   modport source (output valid, output top_value, output largest_value,
                   output element_count, output status, input ready);
   modport sink   (input valid, input top_value, input largest_value,
                   input element_count, input status, output ready);
endinterface

// ===== hw/rtl/mts_csr.sv =====
// APB-style register block holding the capacity limit.
module mts_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mts_pkg::PADDR_W-1:0]   paddr,
   input  logic [mts_pkg::PDATA_W-1:0]   pwdata,
   output logic [mts_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [mts_pkg::CNT_W-1:0]     capacity_limit
);

   logic [mts_pkg::CNT_W-1:0] limit_ff;
   logic [mts_pkg::CNT_W-1:0] limit_in;
   logic                      hit;

   assign hit    = (paddr == mts_pkg::REG_CAPACITY_LIMIT);
   assign pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && hit) begin
         limit_in = pwdata[mts_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mts_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata         = hit ? mts_pkg::PDATA_W'(limit_ff) : '0;
   assign capacity_limit = limit_ff;

endmodule

// ===== hw/rtl/mts_store.sv =====
// Entry store: one write port, one registered read port.
module mts_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [mts_pkg::ADDR_W-1:0]    wr_addr,
   input  mts_pkg::entry_type            wr_data,
   input  logic                          rd_en,
   input  logic [mts_pkg::ADDR_W-1:0]    rd_addr,
   output mts_pkg::entry_type            rd_data
);

   mts_pkg::entry_type mem [mts_pkg::STACK_DEPTH];
   mts_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/max_tracking_stack_unit.sv =====
// Top level of the max tracking stack: control, count and response register.
//
//   channel   direction   protocol         contents
//   req       in          valid/ready      req_type, push_value
//   rsp       out         valid/ready      top_value, largest_value, element_count, status
//   csr       in/out      APB-style        capacity_limit at byte address 0
//
// Each transaction runs as an accept step, which reads the top entry from
// the store's registered read port, and an execute step, which applies the
// operation, writes back a push and loads the response register. A stalled
// response holds the execute step until taken, yet the next request is
// accepted while the response waits.
// Reset clears the count, the FSM and the response valid; store contents
// stay undefined and are read only below the count.
module max_tracking_stack_unit (
   input  logic                          clock,
   input  logic                          reset,
   mts_req_if.sink                       req,
   mts_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mts_pkg::PADDR_W-1:0]   paddr,
   input  logic [mts_pkg::PDATA_W-1:0]   pwdata,
   output logic [mts_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type                            state_ff, state_in;
   logic [mts_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [mts_pkg::REQ_W-1:0]            op_ff;
   logic signed [mts_pkg::DATA_W-1:0]    val_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [mts_pkg::DATA_W-1:0]    rsp_top_ff, rsp_top_in;
   logic signed [mts_pkg::DATA_W-1:0]    rsp_max_ff, rsp_max_in;
   logic [mts_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;

   logic [mts_pkg::CNT_W-1:0]            capacity_limit;
   logic [mts_pkg::CNT_W-1:0]            limit_eff;

   logic                                 accept;
   logic                                 out_free;
   logic                                 exec_go;
   logic                                 wr_en;
   mts_pkg::entry_type                   wr_data;
   mts_pkg::entry_type                   rd_data;
   logic [mts_pkg::ADDR_W-1:0]           top_addr;
   logic signed [mts_pkg::DATA_W-1:0]    new_max;

   mts_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .capacity_limit (capacity_limit)
   );

   // Read the current top on acceptance; the count cannot move until the
   // next execute step, so the read always sees the last write-back.
   assign top_addr = mts_pkg::ADDR_W'(count_ff - mts_pkg::CNT_W'(1));

   mts_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[mts_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (top_addr),
      .rd_data (rd_data)
   );

   // Clamp the programmed limit to the store depth.
   assign limit_eff = (capacity_limit > mts_pkg::DEPTH_CNT) ? mts_pkg::DEPTH_CNT
                                                           : capacity_limit;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign exec_go   = (state_ff == ST_EXEC) && out_free;

   // Running maximum for a push: keep the old one unless the stack is empty or the new value beats it.
   assign new_max = ((count_ff != '0) && !(val_ff > rd_data.maxv)) ? rd_data.maxv : val_ff;
   assign wr_data = '{value: val_ff, maxv: new_max};

   // Execute step: decide the outcome, write back pushes, update the count.
   always_comb begin
      count_in      = count_ff;
      wr_en         = 1'b0;
      rsp_top_in    = rsp_top_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_status_in = rsp_status_ff;
      if (exec_go) begin
         rsp_top_in    = '0;
         rsp_max_in    = '0;
         rsp_status_in = mts_pkg::STS_OK;
         case (mts_pkg::req_code_type'(op_ff))
            mts_pkg::REQ_PUSH: begin
               if (count_ff >= limit_eff) begin
                  rsp_status_in = mts_pkg::STS_OVERFLOW;
               end else begin
                  wr_en      = 1'b1;
                  count_in   = count_ff + mts_pkg::CNT_W'(1);
                  rsp_max_in = new_max;
               end
            end
            mts_pkg::REQ_POP,
            mts_pkg::REQ_PEEK: begin
               if (count_ff == '0) begin
                  rsp_status_in = mts_pkg::STS_UNDERFLOW;
               end else begin
                  rsp_top_in = rd_data.value;
                  rsp_max_in = rd_data.maxv;
                  if (mts_pkg::req_code_type'(op_ff) == mts_pkg::REQ_POP) begin
                     count_in = count_ff - mts_pkg::CNT_W'(1);
                  end
               end
            end
            default: begin
               // unused code: no state change, zero payload, status ok
            end
         endcase
      end
   end

   // Advance the FSM: hold in execute while the response register is full and not taken.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set by the execute step, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture the request, hold the response.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req.req_type;
         val_ff <= req.push_value;
      end
      rsp_top_ff    <= rsp_top_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The count shown is the one left after the operation.
   logic [mts_pkg::CNT_W-1:0] rsp_count_ff;
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.top_value     = rsp_top_ff;
   assign rsp.largest_value = rsp_max_ff;
   assign rsp.element_count = rsp_count_ff;
   assign rsp.status        = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mts_pkg::DEPTH_CNT)
      else $error("entry count beyond store depth");

   a_write_below_limit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < limit_eff))
      else $error("store write at or above the limit");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("execute step did not load the response");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !exec_go |=> $stable(count_ff))
      else $error("count moved outside an execute step");
`endif

endmodule
